/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

/* hdl/dtcr_pkg.sv */
`default_nettype none

package dtcr_pkg;

    localparam int ELEM_W          = 64;
    localparam int DIM_W           = 16;
    localparam int NUM_DIMS        = 4;
    localparam int MAX_SPARSE_DIMS = 4;
    localparam int SD_W            = 3;
    localparam int LEN_W           = 7;
    localparam int KIND_W          = 3;
    localparam int COL_W           = 6;
    localparam int NZR_W           = 32;
    localparam int PADDR_W         = 5;
    localparam int PDATA_W         = 32;
    localparam int REG_IDX_W       = 3;

    // register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_SPARSE_DIMS  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DIM_SIZE_0   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DIM_SIZE_1   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DIM_SIZE_2   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DIM_SIZE_3   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ROW_LENGTH   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ELEMENT_KIND = 3'd6;

    // element kinds
    localparam logic [KIND_W-1:0] KIND_INT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FP16  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FP32  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FP64  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CPX64 = 3'd4;

    typedef struct packed {
        logic [ELEM_W-1:0] element;
    } t_in_item;

    typedef struct packed {
        logic [DIM_W-1:0]  coord_0;
        logic [DIM_W-1:0]  coord_1;
        logic [DIM_W-1:0]  coord_2;
        logic [DIM_W-1:0]  coord_3;
        logic [NZR_W-1:0]  nonzero_row_number;
        logic [COL_W-1:0]  column;
        logic [ELEM_W-1:0] value;
        logic              last_of_row;
    } t_out_item;

    typedef logic [NUM_DIMS-1:0][DIM_W-1:0] t_coords;

    // effective configuration, already clamped
    typedef struct packed {
        logic [SD_W-1:0]   sparse_dims;
        t_coords           dim_size;
        logic [LEN_W-1:0]  row_length;
        logic [KIND_W-1:0] element_kind;
    } t_cfg;

    // float kinds ignore the sign bit; unknown kinds use the integer test
    function automatic logic elem_is_zero(input logic [KIND_W-1:0] kind,
                                          input logic [ELEM_W-1:0] e);
        logic z;
        unique case (kind)
            KIND_FP16:  z = (e[14:0] == '0);
            KIND_FP32:  z = (e[30:0] == '0);
            KIND_FP64:  z = (e[62:0] == '0);
            KIND_CPX64: z = (e[30:0] == '0) && (e[62:32] == '0);
            default:    z = (e == '0);
        endcase
        return z;
    endfunction

endpackage

`default_nettype wire

/* hdl/dtcr_stream_if.sv */
`default_nettype none

interface dtcr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/dtcr_row_ram.sv */
`default_nettype none

module dtcr_row_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/dtcr_cfg_regs.sv */
`default_nettype none

module dtcr_cfg_regs #(
    parameter int MAX_ROW_LENGTH = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [dtcr_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [dtcr_pkg::PDATA_W-1:0]   pwdata,
    output logic      [dtcr_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    output dtcr_pkg::t_cfg                      o_cfg
);

    localparam logic [dtcr_pkg::LEN_W-1:0] LEN_MAX = dtcr_pkg::LEN_W'(MAX_ROW_LENGTH);
    localparam logic [dtcr_pkg::SD_W-1:0]  SD_MAX  =
        dtcr_pkg::SD_W'(dtcr_pkg::MAX_SPARSE_DIMS);

    logic [dtcr_pkg::SD_W-1:0]   r_sparse_dims;
    dtcr_pkg::t_coords           r_dim_size;
    logic [dtcr_pkg::LEN_W-1:0]  r_row_length;
    logic [dtcr_pkg::KIND_W-1:0] r_element_kind;

    logic [dtcr_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_en;

    assign reg_idx = paddr[dtcr_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sparse_dims  <= dtcr_pkg::SD_W'(1);
            r_dim_size     <= {dtcr_pkg::NUM_DIMS{dtcr_pkg::DIM_W'(1)}};
            r_row_length   <= dtcr_pkg::LEN_W'(1);
            r_element_kind <= dtcr_pkg::KIND_INT;
        end else if (wr_en) begin
            unique case (reg_idx)
                dtcr_pkg::REG_SPARSE_DIMS:  r_sparse_dims  <= pwdata[dtcr_pkg::SD_W-1:0];
                dtcr_pkg::REG_DIM_SIZE_0:   r_dim_size[0]  <= pwdata[dtcr_pkg::DIM_W-1:0];
                dtcr_pkg::REG_DIM_SIZE_1:   r_dim_size[1]  <= pwdata[dtcr_pkg::DIM_W-1:0];
                dtcr_pkg::REG_DIM_SIZE_2:   r_dim_size[2]  <= pwdata[dtcr_pkg::DIM_W-1:0];
                dtcr_pkg::REG_DIM_SIZE_3:   r_dim_size[3]  <= pwdata[dtcr_pkg::DIM_W-1:0];
                dtcr_pkg::REG_ROW_LENGTH:   r_row_length   <= pwdata[dtcr_pkg::LEN_W-1:0];
                dtcr_pkg::REG_ELEMENT_KIND: r_element_kind <= pwdata[dtcr_pkg::KIND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            dtcr_pkg::REG_SPARSE_DIMS:  prdata = dtcr_pkg::PDATA_W'(r_sparse_dims);
            dtcr_pkg::REG_DIM_SIZE_0:   prdata = dtcr_pkg::PDATA_W'(r_dim_size[0]);
            dtcr_pkg::REG_DIM_SIZE_1:   prdata = dtcr_pkg::PDATA_W'(r_dim_size[1]);
            dtcr_pkg::REG_DIM_SIZE_2:   prdata = dtcr_pkg::PDATA_W'(r_dim_size[2]);
            dtcr_pkg::REG_DIM_SIZE_3:   prdata = dtcr_pkg::PDATA_W'(r_dim_size[3]);
            dtcr_pkg::REG_ROW_LENGTH:   prdata = dtcr_pkg::PDATA_W'(r_row_length);
            dtcr_pkg::REG_ELEMENT_KIND: prdata = dtcr_pkg::PDATA_W'(r_element_kind);
            default:                    prdata = '0;
        endcase
    end

    // clamp: zero acts as one, large values saturate
    always_comb begin
        if (r_sparse_dims == '0) begin
            o_cfg.sparse_dims = dtcr_pkg::SD_W'(1);
        end else if (r_sparse_dims > SD_MAX) begin
            o_cfg.sparse_dims = SD_MAX;
        end else begin
            o_cfg.sparse_dims = r_sparse_dims;
        end

        for (int d = 0; d < dtcr_pkg::NUM_DIMS; d++) begin
            o_cfg.dim_size[d] = (r_dim_size[d] == '0) ? dtcr_pkg::DIM_W'(1) : r_dim_size[d];
        end

        if (r_row_length == '0) begin
            o_cfg.row_length = dtcr_pkg::LEN_W'(1);
        end else if (r_row_length > LEN_MAX) begin
            o_cfg.row_length = LEN_MAX;
        end else begin
            o_cfg.row_length = r_row_length;
        end

        o_cfg.element_kind = r_element_kind;
    end

endmodule

`default_nettype wire

/* hdl/dtcr_coord_ctr.sv */
`default_nettype none

module dtcr_coord_ctr (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire dtcr_pkg::t_cfg               i_cfg,
    input  wire logic                         i_advance,
    input  wire logic                         i_row_emitted,
    output dtcr_pkg::t_coords                 o_coord,
    output logic      [dtcr_pkg::NZR_W-1:0]   o_emitted
);

    dtcr_pkg::t_coords           r_coord;
    dtcr_pkg::t_coords           n_coord;
    logic [dtcr_pkg::NZR_W-1:0]  r_emitted;
    logic [dtcr_pkg::NZR_W-1:0]  n_emitted;

    // mixed-radix increment, innermost used dimension first
    always_comb begin
        logic               carry;
        logic [dtcr_pkg::DIM_W:0] nxt;
        carry   = 1'b1;
        n_coord = r_coord;
        for (int d = dtcr_pkg::NUM_DIMS - 1; d >= 0; d--) begin
            nxt = {1'b0, r_coord[d]} + (dtcr_pkg::DIM_W + 1)'(1);
            if (carry && (d < int'(i_cfg.sparse_dims))) begin
                if (nxt < {1'b0, i_cfg.dim_size[d]}) begin
                    n_coord[d] = nxt[dtcr_pkg::DIM_W-1:0];
                    carry      = 1'b0;
                end else begin
                    n_coord[d] = '0;
                end
            end
        end
        // carry out of the outermost dimension ends the tensor
        if (carry) begin
            n_emitted = '0;
        end else begin
            n_emitted = r_emitted + dtcr_pkg::NZR_W'(i_row_emitted);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord   <= '0;
            r_emitted <= '0;
        end else if (i_advance) begin
            r_coord   <= n_coord;
            r_emitted <= n_emitted;
        end
    end

    assign o_coord   = r_coord;
    assign o_emitted = r_emitted;

endmodule

`default_nettype wire

/* hdl/dense_to_coo_rows_unit.sv */
// Elements are taken one per cycle while a row loads into the row RAM.
// A completed row with a nonzero element is read back one result per cycle while
// the receiver is ready; the first result is valid once the state has switched to
// read-out and the RAM read register has loaded. No element is taken while a row is
// read out.
// Synchronous active-low reset clears control and config; the RAM is not cleared.
`default_nettype none
`include "assert_macros.svh"

module dense_to_coo_rows_unit #(
    parameter int MAX_ROW_LENGTH = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    dtcr_stream_if.sink                         i_elem,
    dtcr_stream_if.source                       o_coo,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [dtcr_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [dtcr_pkg::PDATA_W-1:0]   pwdata,
    output logic      [dtcr_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready
);

    localparam int AW = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
    localparam int IW = $clog2(MAX_ROW_LENGTH + 1);

    typedef enum logic {ST_LOAD, ST_EMIT} t_state;

    dtcr_pkg::t_cfg              cfg;
    dtcr_pkg::t_coords           cur_coord;
    logic [dtcr_pkg::NZR_W-1:0]  cur_emitted;

    t_state                      r_state,  n_state;
    logic [AW-1:0]               r_fill,   n_fill;
    logic                        r_has_nz, n_has_nz;
    logic [IW-1:0]               r_rd_idx, n_rd_idx;
    logic [dtcr_pkg::LEN_W-1:0]  r_len,    n_len;
    logic                        r_dv,     n_dv;
    logic [dtcr_pkg::COL_W-1:0]  r_col,    n_col;
    logic                        r_last,   n_last;
    dtcr_pkg::t_coords           r_coord,  n_coord;
    logic [dtcr_pkg::NZR_W-1:0]  r_nzrow,  n_nzrow;
    dtcr_pkg::t_coords           r_ocoord, n_ocoord;
    logic [dtcr_pkg::NZR_W-1:0]  r_onzrow, n_onzrow;

    logic                        in_acc;
    logic                        elem_zero;
    logic                        row_nz;
    logic                        row_end;
    logic                        advance;
    logic                        emit_row;
    logic                        rd_en;
    logic                        rd_last;
    logic [dtcr_pkg::ELEM_W-1:0] rd_data;

    dtcr_cfg_regs #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dtcr_coord_ctr u_coord (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_advance     (advance),
        .i_row_emitted (emit_row),
        .o_coord       (cur_coord),
        .o_emitted     (cur_emitted)
    );

    dtcr_row_ram #(
        .DEPTH (MAX_ROW_LENGTH),
        .WIDTH (dtcr_pkg::ELEM_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_fill),
        .i_wdata (i_elem.data.element),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    assign i_elem.ready = (r_state == ST_LOAD);
    assign in_acc       = i_elem.valid && i_elem.ready;
    assign elem_zero    = dtcr_pkg::elem_is_zero(cfg.element_kind, i_elem.data.element);
    assign row_nz       = r_has_nz || !elem_zero;
    assign row_end      = !((dtcr_pkg::LEN_W'(r_fill) + dtcr_pkg::LEN_W'(1)) < cfg.row_length);
    assign advance      = in_acc && row_end;
    assign emit_row     = advance && row_nz;

    // the RAM read register doubles as the output register
    assign rd_en   = (r_state == ST_EMIT) && (!r_dv || o_coo.ready);
    assign rd_last = (dtcr_pkg::LEN_W'(r_rd_idx) + dtcr_pkg::LEN_W'(1)) == r_len;

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_has_nz = r_has_nz;
        n_rd_idx = r_rd_idx;
        n_len    = r_len;
        n_col    = r_col;
        n_last   = r_last;
        n_coord  = r_coord;
        n_nzrow  = r_nzrow;
        n_ocoord = r_ocoord;
        n_onzrow = r_onzrow;

        if (rd_en) begin
            n_dv = 1'b1;
        end else if (o_coo.ready) begin
            n_dv = 1'b0;
        end else begin
            n_dv = r_dv;
        end

        unique case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (row_end) begin
                        n_fill   = '0;
                        n_has_nz = 1'b0;
                        if (row_nz) begin
                            // capture the row header before the counter moves on
                            for (int d = 0; d < dtcr_pkg::NUM_DIMS; d++) begin
                                n_coord[d] = (d < int'(cfg.sparse_dims)) ? cur_coord[d] : '0;
                            end
                            n_nzrow  = cur_emitted;
                            n_len    = cfg.row_length;
                            n_rd_idx = '0;
                            n_state  = ST_EMIT;
                        end
                    end else begin
                        n_fill   = r_fill + AW'(1);
                        n_has_nz = row_nz;
                    end
                end
            end
            ST_EMIT: begin
                if (rd_en) begin
                    n_rd_idx = r_rd_idx + IW'(1);
                    n_col    = dtcr_pkg::COL_W'(r_rd_idx);
                    n_last   = rd_last;
                    // header moves to the output only with a new request
                    n_ocoord = r_coord;
                    n_onzrow = r_nzrow;
                    if (rd_last) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_fill   <= '0;
            r_has_nz <= 1'b0;
            r_rd_idx <= '0;
            r_dv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_has_nz <= n_has_nz;
            r_rd_idx <= n_rd_idx;
            r_dv     <= n_dv;
            r_len    <= n_len;
            r_col    <= n_col;
            r_last   <= n_last;
            r_coord  <= n_coord;
            r_nzrow  <= n_nzrow;
            r_ocoord <= n_ocoord;
            r_onzrow <= n_onzrow;
        end
    end

    assign o_coo.valid                   = r_dv;
    assign o_coo.data.coord_0            = r_ocoord[0];
    assign o_coo.data.coord_1            = r_ocoord[1];
    assign o_coo.data.coord_2            = r_ocoord[2];
    assign o_coo.data.coord_3            = r_ocoord[3];
    assign o_coo.data.nonzero_row_number = r_onzrow;
    assign o_coo.data.column             = r_col;
    assign o_coo.data.value              = rd_data;
    assign o_coo.data.last_of_row        = r_last;

    // read-out never runs past the captured row length
    `ASSERT_ALWAYS(a_rd_in_row, i_clk, i_rst_n, (r_state == ST_EMIT) |-> (dtcr_pkg::LEN_W'(r_rd_idx) < r_len))
    // a fresh read-out starts at column zero
    `ASSERT_ALWAYS(a_emit_start, i_clk, i_rst_n, ((r_state == ST_LOAD) ##1 (r_state == ST_EMIT)) |-> (r_rd_idx == '0))
    // the single row buffer is never written and read in the same cycle
    `ASSERT_NEVER(a_wr_rd_excl, i_clk, i_rst_n, in_acc && rd_en)
    // during read-out the fill position is back at zero with no nonzero flag pending
    `ASSERT_ALWAYS(a_fill_in_row, i_clk, i_rst_n, (r_state == ST_EMIT) |-> (r_fill == '0) && !r_has_nz)

endmodule

`default_nettype wire

/* tb/sv/coo_row_checker.sv */
`timescale 1ns / 1ps

module coo_row_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_elem_valid,
    input  wire logic                         i_elem_ready,
    input  dtcr_pkg::t_in_item                i_elem_data,
    input  wire logic                         i_coo_valid,
    input  wire logic                         i_coo_ready,
    input  dtcr_pkg::t_out_item               i_coo_data,
    input  wire logic                         i_psel,
    input  wire logic                         i_penable,
    input  wire logic                         i_pwrite,
    input  wire logic                         i_pready,
    input  wire logic [dtcr_pkg::PADDR_W-1:0] i_paddr,
    input  wire logic [dtcr_pkg::PDATA_W-1:0] i_pwdata,
    output int                                o_fail_count,
    output int                                o_pending
);
    import dtcr_pkg::*;

    localparam int ROW_SLOTS = 64;

    // shadow of the register file
    logic [SD_W-1:0]   sd_reg;
    logic [DIM_W-1:0]  extent_reg [NUM_DIMS];
    logic [LEN_W-1:0]  len_reg;
    logic [KIND_W-1:0] kind_reg;

    // shadow of the row state
    logic [ELEM_W-1:0] row_shadow [ROW_SLOTS];
    int unsigned       fill_pos;
    bit                row_nonzero;
    int unsigned       row_coord [NUM_DIMS];
    logic [NZR_W-1:0]  rows_emitted;

    t_out_item coo_expected [$];
    int        mismatches = 0;
    int        waiting = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    function automatic bit elem_zero(input logic [KIND_W-1:0] kind,
                                     input logic [ELEM_W-1:0] e);
        logic [ELEM_W-1:0] mask;
        // float kinds drop the sign bit; complex checks both halves
        case (kind)
            KIND_FP16:  mask = 64'h0000_0000_0000_7FFF;
            KIND_FP32:  mask = 64'h0000_0000_7FFF_FFFF;
            KIND_FP64:  mask = 64'h7FFF_FFFF_FFFF_FFFF;
            KIND_CPX64: mask = 64'h7FFF_FFFF_7FFF_FFFF;
            default:    mask = '1;
        endcase
        return (e & mask) == '0;
    endfunction

    function automatic int unsigned live_dims();
        if (sd_reg == '0) return 1;
        if (sd_reg > MAX_SPARSE_DIMS) return MAX_SPARSE_DIMS;
        return sd_reg;
    endfunction

    function automatic int unsigned live_len();
        if (len_reg == '0) return 1;
        if (len_reg > ROW_SLOTS) return ROW_SLOTS;
        return len_reg;
    endfunction

    // mixed-radix increment, innermost dim fastest; 1 when the tensor wraps
    function automatic bit step_coords();
        int unsigned ext;
        int unsigned nxt;
        for (int d = int'(live_dims()) - 1; d >= 0; d--) begin
            ext = (extent_reg[d] == '0) ? 1 : extent_reg[d];
            nxt = row_coord[d] + 1;
            if (nxt < ext) begin
                row_coord[d] = nxt;
                return 1'b0;
            end
            row_coord[d] = 0;
        end
        return 1'b1;
    endfunction

    task automatic take_element(input logic [ELEM_W-1:0] e);
        int unsigned len;
        int unsigned dims;
        int unsigned pos;
        t_out_item   item;
        pos = fill_pos;
        len = live_len();
        row_shadow[pos] = e;
        if (!elem_zero(kind_reg, e))
            row_nonzero = 1'b1;
        if (pos + 1 < len) begin
            fill_pos = pos + 1;
        end else begin
            if (row_nonzero) begin
                dims = live_dims();
                for (int k = 0; k < int'(len); k++) begin
                    item.coord_0            = DIM_W'(row_coord[0]);
                    item.coord_1            = (dims > 1) ? DIM_W'(row_coord[1]) : '0;
                    item.coord_2            = (dims > 2) ? DIM_W'(row_coord[2]) : '0;
                    item.coord_3            = (dims > 3) ? DIM_W'(row_coord[3]) : '0;
                    item.nonzero_row_number = rows_emitted;
                    item.column             = COL_W'(k);
                    item.value              = row_shadow[k];
                    item.last_of_row        = (k + 1 == int'(len));
                    coo_expected.push_back(item);
                end
                rows_emitted = rows_emitted + 1'b1;
            end
            fill_pos    = 0;
            row_nonzero = 1'b0;
            if (step_coords())
                rows_emitted = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (coo_expected.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            mismatches++;
        end else begin
            want = coo_expected.pop_front();
            check_field("coord_0", want.coord_0, got.coord_0);
            check_field("coord_1", want.coord_1, got.coord_1);
            check_field("coord_2", want.coord_2, got.coord_2);
            check_field("coord_3", want.coord_3, got.coord_3);
            check_field("nonzero_row_number", want.nonzero_row_number,
                        got.nonzero_row_number);
            check_field("column", want.column, got.column);
            check_field("value", want.value, got.value);
            check_field("last_of_row", want.last_of_row, got.last_of_row);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sd_reg   = SD_W'(1);
            foreach (extent_reg[d]) extent_reg[d] = DIM_W'(1);
            len_reg  = LEN_W'(1);
            kind_reg = KIND_INT;
            fill_pos     = 0;
            row_nonzero  = 1'b0;
            foreach (row_coord[d]) row_coord[d] = 0;
            rows_emitted = '0;
            coo_expected.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[PADDR_W-1:2])
                    REG_SPARSE_DIMS:  sd_reg        = i_pwdata[SD_W-1:0];
                    REG_DIM_SIZE_0:   extent_reg[0] = i_pwdata[DIM_W-1:0];
                    REG_DIM_SIZE_1:   extent_reg[1] = i_pwdata[DIM_W-1:0];
                    REG_DIM_SIZE_2:   extent_reg[2] = i_pwdata[DIM_W-1:0];
                    REG_DIM_SIZE_3:   extent_reg[3] = i_pwdata[DIM_W-1:0];
                    REG_ROW_LENGTH:   len_reg       = i_pwdata[LEN_W-1:0];
                    REG_ELEMENT_KIND: kind_reg      = i_pwdata[KIND_W-1:0];
                    default: ;
                endcase
            end
            if (i_elem_valid && i_elem_ready)
                take_element(i_elem_data.element);
            if (i_coo_valid && i_coo_ready)
                check_result(i_coo_data);
        end
        waiting = coo_expected.size();
    end

endmodule

/* tb/sv/tb_dense_to_coo_rows_unit.sv */
`timescale 1ns / 1ps

module tb_dense_to_coo_rows_unit;
    import dtcr_pkg::*;

    localparam int RANDOM_ITEMS  = 470;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 300000;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fails;
    int pending;

    bit                hold_go = 1'b0;
    logic [KIND_W-1:0] kind_now = KIND_INT;
    logic [ELEM_W-1:0] batch [$];

    dtcr_stream_if #(.T(t_in_item))  elem_if ();
    dtcr_stream_if #(.T(t_out_item)) coo_if ();

    always #2 i_clk = ~i_clk;

    dense_to_coo_rows_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_elem  (elem_if),
        .o_coo   (coo_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    coo_row_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_elem_valid (elem_if.valid),
        .i_elem_ready (elem_if.ready),
        .i_elem_data  (elem_if.data),
        .i_coo_valid  (coo_if.valid),
        .i_coo_ready  (coo_if.ready),
        .i_coo_data   (coo_if.data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fails),
        .o_pending    (pending)
    );

    // waits until every predicted result is out, then lets the block settle
    task automatic wait_idle();
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // leaves psel/penable up; write_config drops them after the last write
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic write_config(input logic [31:0] sd, d0, d1, d2, d3, rl, kd,
                                input bit junk);
        logic [31:0] noise;
        wait_idle();
        // optional garbage above each field's width
        noise = junk ? $urandom : 32'h0;
        reg_write(REG_SPARSE_DIMS,  sd | (noise & ~32'h7));
        reg_write(REG_DIM_SIZE_0,   d0 | (noise & ~32'hFFFF));
        reg_write(REG_DIM_SIZE_1,   d1 | (noise & ~32'hFFFF));
        reg_write(REG_DIM_SIZE_2,   d2 | (noise & ~32'hFFFF));
        reg_write(REG_DIM_SIZE_3,   d3 | (noise & ~32'hFFFF));
        reg_write(REG_ROW_LENGTH,   rl | (noise & ~32'h7F));
        reg_write(REG_ELEMENT_KIND, kd | (noise & ~32'h7));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        kind_now = kd[KIND_W-1:0];
    endtask

    // zero-like patterns keep the bits the current kind ignores
    function automatic logic [ELEM_W-1:0] pick_element(input logic [KIND_W-1:0] kind,
                                                       input int zero_pct);
        logic [ELEM_W-1:0] e;
        int                r;
        r = $urandom_range(99);
        e = {$urandom, $urandom};
        if (r < zero_pct) begin
            case (kind)
                KIND_FP16:  e = e & ~64'h7FFF;
                KIND_FP32:  e = e & ~64'h7FFF_FFFF;
                KIND_FP64:  e = e & 64'h8000_0000_0000_0000;
                KIND_CPX64: e = e & 64'h8000_0000_8000_0000;
                default:    e = '0;
            endcase
        end else if (r < zero_pct + 8) begin
            e = 64'h1 << $urandom_range(63);
        end else if (r < zero_pct + 10) begin
            e = '1;
        end
        return e;
    endfunction

    task automatic send_batch(input bit use_gaps);
        int burst;
        int gap;
        burst = $urandom_range(1, 20);
        foreach (batch[i]) begin
            elem_if.valid <= 1'b1;
            elem_if.data  <= t_in_item'(batch[i]);
            do @(posedge i_clk); while (!elem_if.ready);
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                gap   = use_gaps ? $urandom_range(0, 8) : 0;
                if (gap > 0) begin
                    elem_if.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        elem_if.valid <= 1'b0;
    endtask

    // receiver: random stall modes, plus one long hold-off on request
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        int tick;
        bit hold_used;
        mode      = 0;
        mode_left = 40;
        hold_left = 0;
        tick      = 0;
        hold_used = 1'b0;
        coo_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_go && !hold_used) begin
                hold_used = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(3);
                mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                coo_if.ready <= 1'b0;
            end else begin
                case (mode)
                    0:       coo_if.ready <= 1'b1;
                    1:       coo_if.ready <= 1'($urandom_range(1));
                    2:       coo_if.ready <= ($urandom_range(3) == 0);
                    default: coo_if.ready <= tick[2];
                endcase
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int          random_sent;
        int          r;
        int          zero_pct;
        int          eff_len;
        int          count;
        bit          use_gaps;
        logic [31:0] sd;
        logic [31:0] ext [NUM_DIMS];
        logic [31:0] rl;
        logic [31:0] kd;

        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        elem_if.valid <= 1'b0;
        elem_if.data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: each one-element row ends the tensor
        batch = '{64'h0, 64'h1, 64'hFFFF_FFFF_FFFF_FFFF};
        send_batch(1'b1);

        // fp16: negative zero and ignored high bits vs NaN
        write_config(2, 2, 2, 1, 1, 2, KIND_FP16, 1'b0);
        batch = '{64'h8000, 64'hFFFF_FFFF_FFFF_0000, 64'h7E00, 64'h8000};
        send_batch(1'b1);

        write_config(1, 3, 1, 1, 1, 1, KIND_FP32, 1'b0);
        batch = '{64'h8000_0000, 64'h7FC0_0000, 64'hFFFF_FFFF_8000_0000};
        send_batch(1'b1);

        write_config(1, 3, 1, 1, 1, 1, KIND_FP64, 1'b0);
        batch = '{64'h8000_0000_0000_0000, 64'h7FF8_0000_0000_0000};
        send_batch(1'b1);

        // complex: nonzero imaginary half alone makes the row live
        write_config(3, 2, 1, 2, 1, 3, KIND_CPX64, 1'b0);
        batch = '{64'h8000_0000_8000_0000, 64'h0000_0001_0000_0000, 64'h0,
                  64'h8000_0000_0000_0000, 64'h8000_0000, 64'h0};
        send_batch(1'b1);

        // unknown kind, zero sparse dims, zero row length, zero extent
        write_config(0, 0, 0, 0, 0, 0, 7, 1'b0);
        batch = '{64'h8000_0000_0000_0000, 64'h0};
        send_batch(1'b1);

        // back-pressure: receiver holds off while the sender streams
        write_config(4, 65535, 2, 3, 1, 8, KIND_INT, 1'b0);
        batch.delete();
        repeat (48) batch.push_back(pick_element(KIND_INT, 0));
        hold_go <= 1'b1;
        send_batch(1'b0);
        random_sent = 48;

        while (random_sent < RANDOM_ITEMS) begin
            r  = $urandom_range(9);
            sd = (r == 0) ? 32'(($urandom_range(3) == 0) ? 0 : $urandom_range(5, 7))
                          : 32'($urandom_range(1, 4));
            foreach (ext[d]) begin
                r = $urandom_range(19);
                case (r)
                    0:       ext[d] = 0;
                    1:       ext[d] = 65535;
                    2:       ext[d] = $urandom_range(65535);
                    default: ext[d] = $urandom_range(1, 4);
                endcase
            end
            r = $urandom_range(19);
            case (r)
                0:       rl = 0;
                1:       rl = 64;
                2:       rl = $urandom_range(65, 127);
                3:       rl = $urandom_range(9, 63);
                default: rl = $urandom_range(1, 8);
            endcase
            kd = ($urandom_range(9) < 8) ? $urandom_range(4) : $urandom_range(5, 7);
            write_config(sd, ext[0], ext[1], ext[2], ext[3], rl, kd,
                         $urandom_range(5) == 0);

            eff_len  = (rl == 0) ? 1 : (rl > 64) ? 64 : int'(rl);
            count    = (eff_len > 8) ? eff_len * $urandom_range(1, 2) + $urandom_range(0, 3)
                                     : $urandom_range(8, 40);
            zero_pct = $urandom_range(20, 90);
            use_gaps = ($urandom_range(3) != 0);
            batch.delete();
            repeat (count) batch.push_back(pick_element(kind_now, zero_pct));
            send_batch(use_gaps);
            random_sent += count;
        end

        wait_idle();
        if (fails == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
